// ----- rtl/ipv4_prefix_blocklist_table_unit_assert.svh -----
// Assertion macros used by the table engine (ipbl_back) of the prefix blocklist table RTL.
`ifndef IPV4_PREFIX_BLOCKLIST_TABLE_UNIT_ASSERT_SVH
`define IPV4_PREFIX_BLOCKLIST_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define IPBL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ipbl assertion failed");
`define IPBL_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("ipbl forbidden condition seen");
`else
`define IPBL_ASSERT(lbl, prop)
`define IPBL_NEVER(lbl, cond)
`endif
`endif

// ----- rtl/ipbl_pkg.sv -----
// Types, constants and helper functions of the prefix blocklist table.
`timescale 1ns / 1ps
package ipbl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int ADDR_W = 32;
  localparam int PLEN_W = 6;
  localparam int COUNT_OUT_W = 9;
  localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [PLEN_W-1:0] FULL_PREFIX = 6'd32;
  localparam int ENTRY_W = 2 * ADDR_W;

  typedef enum logic [1:0] {
    CMD_CHECK    = 2'd0,
    CMD_ADD_HOST = 2'd1,
    CMD_APPEND   = 2'd2,
    CMD_CLEAR    = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_LISTED = 2'd2
  } status_t;

  typedef struct packed {
    command_t          cmd;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] mask;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] mask;
    if (len == '0) begin
      mask = '0;
    end else if (len >= FULL_PREFIX) begin
      mask = ALL_ONES;
    end else begin
      mask = ~(ALL_ONES >> len);
    end
    return mask;
  endfunction

endpackage

// ----- rtl/ipbl_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module ipbl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ipbl_front.sv -----
// Front stage: takes requests, builds the prefix mask and feeds the queue.
`timescale 1ns / 1ps
module ipbl_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          command,
  input  logic [ipbl_pkg::ADDR_W-1:0]         address,
  input  logic [ipbl_pkg::PLEN_W-1:0]         prefix_len,
  input  ipbl_pkg::queue_status_t             q_status,
  output logic                                push,
  output ipbl_pkg::req_t                      push_req
);

  logic                 front_valid;
  ipbl_pkg::req_t       front_req;
  ipbl_pkg::req_t       new_req;
  ipbl_pkg::command_t   cmd_in;
  logic [ipbl_pkg::ADDR_W-1:0] mask_in;
  logic                 accept;

  assign cmd_in  = ipbl_pkg::command_t'(command);
  assign mask_in = ipbl_pkg::prefix_mask(prefix_len);

  always_comb begin
    new_req.cmd  = cmd_in;
    new_req.addr = address;
    new_req.mask = ipbl_pkg::ALL_ONES;
    if (cmd_in == ipbl_pkg::CMD_APPEND) begin
      new_req.addr = address & mask_in;
      new_req.mask = mask_in;
    end
  end

  assign push     = front_valid && !q_status.full;
  assign busy     = front_valid && q_status.full;
  assign accept   = start && !busy;
  assign push_req = front_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
    if (accept) begin
      front_req <= new_req;
    end
  end

endmodule

// ----- rtl/ipbl_queue.sv -----
// Short request queue between the front stage and the table engine.
`timescale 1ns / 1ps
module ipbl_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  ipbl_pkg::req_t          push_req,
  input  logic                    pop,
  output ipbl_pkg::req_t          head,
  output ipbl_pkg::queue_status_t q_status
);

  ipbl_pkg::req_t                  slots [ipbl_pkg::QUEUE_DEPTH];
  logic [ipbl_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ipbl_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ipbl_pkg::QCNT_W-1:0]     fill;

  localparam logic [ipbl_pkg::QPTR_W-1:0] LAST_SLOT = ipbl_pkg::QPTR_W'(ipbl_pkg::QUEUE_DEPTH - 1);
  localparam logic [ipbl_pkg::QCNT_W-1:0] FULL_FILL = ipbl_pkg::QCNT_W'(ipbl_pkg::QUEUE_DEPTH);

  assign head           = slots[rd_ptr];
  assign q_status.full  = (fill == FULL_FILL);
  assign q_status.empty = (fill == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

// ----- rtl/ipbl_back.sv -----
// Table engine: holds the entry count, scans and writes the table memory and issues results.
`timescale 1ns / 1ps
`include "ipv4_prefix_blocklist_table_unit_assert.svh"
module ipbl_back (
  input  logic                              clk,
  input  logic                              rst,
  input  ipbl_pkg::req_t                    head,
  input  ipbl_pkg::queue_status_t           q_status,
  output logic                              pop,
  output logic                              done,
  output logic                              hit,
  output logic [1:0]                        status,
  output logic [ipbl_pkg::COUNT_OUT_W-1:0]  entry_count
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                           state, state_next;
  ipbl_pkg::req_t                   cur, cur_next;
  logic [ipbl_pkg::CNT_W-1:0]       count, count_next;
  logic [ipbl_pkg::CNT_W-1:0]       scan_idx, scan_idx_next;
  logic                             cmp_valid, cmp_valid_next;
  logic                             done_next, hit_next;
  ipbl_pkg::status_t                status_reg, status_next;

  logic                             ram_we;
  logic [ipbl_pkg::IDX_W-1:0]       ram_waddr;
  logic [ipbl_pkg::ENTRY_W-1:0]     ram_wdata;
  logic [ipbl_pkg::ENTRY_W-1:0]     ram_rdata;
  logic [ipbl_pkg::ADDR_W-1:0]      ent_addr, ent_mask;
  logic                             full, match;

  ipbl_ram #(
    .WIDTH(ipbl_pkg::ENTRY_W),
    .DEPTH(ipbl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_idx[ipbl_pkg::IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  assign ent_addr  = ram_rdata[ipbl_pkg::ENTRY_W-1:ipbl_pkg::ADDR_W];
  assign ent_mask  = ram_rdata[ipbl_pkg::ADDR_W-1:0];
  assign match     = cmp_valid && ((cur.addr & ent_mask) == ent_addr);
  assign full      = (count == ipbl_pkg::FULL_COUNT);
  assign ram_waddr = count[ipbl_pkg::IDX_W-1:0];

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    count_next     = count;
    scan_idx_next  = scan_idx;
    cmp_valid_next = 1'b0;
    done_next      = 1'b0;
    hit_next       = 1'b0;
    status_next    = ipbl_pkg::ST_DONE;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_wdata      = {head.addr, head.mask};
    unique case (state)
      S_IDLE: begin
        if (!q_status.empty) begin
          pop = 1'b1;
          case (head.cmd)
            ipbl_pkg::CMD_CLEAR: begin
              count_next = '0;
              done_next  = 1'b1;
            end
            ipbl_pkg::CMD_APPEND: begin
              done_next = 1'b1;
              if (full) begin
                status_next = ipbl_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            default: begin
              if (head.cmd == ipbl_pkg::CMD_ADD_HOST && full) begin
                done_next   = 1'b1;
                status_next = ipbl_pkg::ST_FULL;
              end else begin
                cur_next      = head;
                scan_idx_next = '0;
                state_next    = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!match && scan_idx < count) begin
          scan_idx_next  = scan_idx + 1'b1;
          cmp_valid_next = 1'b1;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          if (cur.cmd == ipbl_pkg::CMD_CHECK) begin
            hit_next = match;
          end else if (match) begin
            status_next = ipbl_pkg::ST_LISTED;
          end else begin
            ram_we     = 1'b1;
            ram_wdata  = {cur.addr, ipbl_pkg::ALL_ONES};
            count_next = count + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cmp_valid <= cmp_valid_next;
      done      <= done_next;
    end
    cur         <= cur_next;
    scan_idx    <= scan_idx_next;
    hit         <= hit_next;
    status_reg  <= status_next;
    entry_count <= ipbl_pkg::COUNT_OUT_W'(count_next);
  end

  assign status = status_reg;

  `IPBL_ASSERT(a_count_bound, count <= ipbl_pkg::FULL_COUNT)
  `IPBL_NEVER(a_no_write_when_full, ram_we && full)
  `IPBL_ASSERT(a_full_status_count, (done && status_reg == ipbl_pkg::ST_FULL) |-> full)
  `IPBL_NEVER(a_hit_only_on_done, hit && !done)

endmodule

// ----- rtl/ipv4_prefix_blocklist_table_unit.sv -----
// Top level of the IPv4 prefix blocklist table.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low; a two-entry queue behind
// the input stage lets requests wait while the table engine works. Clear and append
// finish in the engine's idle state with no scan, and done is registered. Check and
// add-host read the stored entries one per cycle through the table memory's single
// read port and stop at the first match or after the last entry (a full table holds
// 256 entries). Each result appears on hit, status and entry_count for exactly one
// cycle with done high; results come in request order and the receiver has no way
// to hold them off.
module ipv4_prefix_blocklist_table_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command,
  input  logic [ipbl_pkg::ADDR_W-1:0]       address,
  input  logic [ipbl_pkg::PLEN_W-1:0]       prefix_len,
  output logic                              done,
  output logic                              hit,
  output logic [1:0]                        status,
  output logic [ipbl_pkg::COUNT_OUT_W-1:0]  entry_count
);

  ipbl_pkg::queue_status_t q_status;
  ipbl_pkg::req_t          push_req;
  ipbl_pkg::req_t          head;
  logic                    push;
  logic                    pop;

  ipbl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .address   (address),
    .prefix_len(prefix_len),
    .q_status  (q_status),
    .push      (push),
    .push_req  (push_req)
  );

  ipbl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .head    (head),
    .q_status(q_status)
  );

  ipbl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .q_status   (q_status),
    .pop        (pop),
    .done       (done),
    .hit        (hit),
    .status     (status),
    .entry_count(entry_count)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the IPv4 prefix blocklist table unit.
`timescale 1ns / 1ps
module tb_top;
  import ipbl_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 300;
  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic                   hit;
    status_t                status;
    logic [COUNT_OUT_W-1:0] count;
  } verdict_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             command;
  logic [ADDR_W-1:0]      address;
  logic [PLEN_W-1:0]      prefix_len;
  logic                   done;
  logic                   hit;
  logic [1:0]             status;
  logic [COUNT_OUT_W-1:0] entry_count;

  logic [ADDR_W-1:0] listed_addr [TABLE_DEPTH];
  logic [ADDR_W-1:0] listed_mask [TABLE_DEPTH];
  int                listed_total = 0;
  verdict_t          expected_verdicts [$];
  int                mismatch_count = 0;
  int                cycle_count = 0;
  int                idle_rate = 0;

  ipv4_prefix_blocklist_table_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .address     (address),
    .prefix_len  (prefix_len),
    .done        (done),
    .hit         (hit),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Lengths above 32 saturate to a full host mask.
  function automatic logic [ADDR_W-1:0] mask_for(logic [PLEN_W-1:0] len);
    logic [ADDR_W-1:0] m;
    m = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      if (i < len) begin
        m[ADDR_W-1-i] = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic logic table_covers(logic [ADDR_W-1:0] addr);
    for (int i = 0; i < listed_total; i++) begin
      if ((addr & listed_mask[i]) == listed_addr[i]) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void store_entry(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] m);
    listed_addr[listed_total] = addr & m;
    listed_mask[listed_total] = m;
    listed_total++;
  endfunction

  function automatic verdict_t predict_verdict(command_t cmd, logic [ADDR_W-1:0] addr,
                                               logic [PLEN_W-1:0] plen);
    verdict_t v;
    v.hit = 1'b0;
    v.status = ST_DONE;
    case (cmd)
      CMD_CHECK: begin
        v.hit = table_covers(addr);
      end
      CMD_ADD_HOST: begin
        if (listed_total >= TABLE_DEPTH) begin
          v.status = ST_FULL;
        end else if (table_covers(addr)) begin
          v.status = ST_LISTED;
        end else begin
          store_entry(addr, ALL_ONES);
        end
      end
      CMD_APPEND: begin
        if (listed_total >= TABLE_DEPTH) begin
          v.status = ST_FULL;
        end else begin
          store_entry(addr, mask_for(plen));
        end
      end
      default: begin
        listed_total = 0;
      end
    endcase
    v.count = COUNT_OUT_W'(listed_total);
    return v;
  endfunction

  task automatic send_request(command_t cmd, logic [ADDR_W-1:0] addr,
                              logic [PLEN_W-1:0] plen);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    address <= addr;
    prefix_len <= plen;
    do @(posedge clk); while (busy);
    expected_verdicts.push_back(predict_verdict(cmd, addr, plen));
    if (idle_rate > 0 && $urandom_range(0, 99) < idle_rate) begin
      gap = $urandom_range(1, 10);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done) begin
      if (expected_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("Unexpected result: hit %0b status %0d count %0d",
                   hit, status, entry_count);
        end
      end else begin
        want = expected_verdicts.pop_front();
        if (hit !== want.hit || status !== want.status || entry_count !== want.count) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("Mismatch: exp hit %0b st %0d cnt %0d, got hit %0b st %0d cnt %0d",
                     want.hit, want.status, want.count, hit, status, entry_count);
          end
        end
      end
    end
  end

  task automatic test_edge_cases();
    idle_rate = 30;
    send_request(CMD_CHECK, 32'h0000_0000, 6'd0);
    send_request(CMD_ADD_HOST, 32'hFFFF_FFFF, 6'h3F);
    send_request(CMD_ADD_HOST, 32'hFFFF_FFFF, 6'd0);
    send_request(CMD_CHECK, 32'hFFFF_FFFF, 6'h3F);
    send_request(CMD_CHECK, 32'hFFFF_FFFE, 6'd0);
    send_request(CMD_APPEND, 32'hC0A8_01FF, 6'd24);
    send_request(CMD_CHECK, 32'hC0A8_0107, 6'd0);
    send_request(CMD_CHECK, 32'hC0A8_0207, 6'd0);
    send_request(CMD_APPEND, 32'h8000_0000, 6'd1);
    send_request(CMD_CHECK, 32'hFFFF_0000, 6'd0);
    send_request(CMD_APPEND, 32'h0000_0001, 6'd31);
    send_request(CMD_CHECK, 32'h0000_0001, 6'd0);
    send_request(CMD_APPEND, 32'h1234_5678, 6'd33);
    send_request(CMD_APPEND, 32'h8765_4321, 6'h3F);
    send_request(CMD_CHECK, 32'h8765_4321, 6'd0);
    send_request(CMD_CHECK, 32'h1234_5679, 6'd0);
    send_request(CMD_ADD_HOST, 32'h1234_5678, 6'd0);
    send_request(CMD_CLEAR, 32'hFFFF_FFFF, 6'h3F);
    send_request(CMD_CHECK, 32'hC0A8_0107, 6'd0);
    send_request(CMD_APPEND, 32'hDEAD_BEEF, 6'd0);
    send_request(CMD_CHECK, $urandom, 6'd0);
    send_request(CMD_ADD_HOST, 32'h0102_0304, 6'd0);
    send_request(CMD_CLEAR, 32'h0000_0000, 6'd0);
  endtask

  task automatic test_full_table();
    logic [ADDR_W-1:0] covered;
    idle_rate = 20;
    send_request(CMD_CLEAR, $urandom, 6'd0);
    while (listed_total < TABLE_DEPTH) begin
      if ($urandom_range(0, 2) == 0) begin
        send_request(CMD_ADD_HOST, $urandom, PLEN_W'($urandom_range(0, 63)));
      end else begin
        send_request(CMD_APPEND, $urandom, PLEN_W'($urandom_range(24, 63)));
      end
    end
    covered = listed_addr[0];
    send_request(CMD_APPEND, $urandom, PLEN_W'($urandom_range(0, 63)));
    send_request(CMD_ADD_HOST, covered, 6'd0);
    send_request(CMD_ADD_HOST, $urandom, 6'd0);
    send_request(CMD_CHECK, listed_addr[TABLE_DEPTH-1], 6'd0);
    send_request(CMD_CHECK, $urandom, 6'd0);
    send_request(CMD_CLEAR, $urandom, PLEN_W'($urandom_range(0, 63)));
    send_request(CMD_CHECK, covered, 6'd0);
  endtask

  task automatic test_random_traffic(int items, int clear_pct, int rate);
    int                sel;
    int                pick;
    command_t          cmd;
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] plen;
    idle_rate = rate;
    for (int n = 0; n < items; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < clear_pct) begin
        cmd = CMD_CLEAR;
      end else if (sel < 45) begin
        cmd = CMD_CHECK;
      end else if (sel < 65) begin
        cmd = CMD_ADD_HOST;
      end else begin
        cmd = CMD_APPEND;
      end
      sel = $urandom_range(0, 99);
      if (listed_total > 0 && sel < 50) begin
        pick = $urandom_range(0, listed_total - 1);
        addr = listed_addr[pick] | ($urandom & ~listed_mask[pick]);
      end else if (sel < 55) begin
        addr = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hFFFF_FFFF;
      end else begin
        addr = $urandom;
      end
      if (cmd == CMD_APPEND && $urandom_range(0, 9) != 0) begin
        plen = PLEN_W'($urandom_range(8, 32));
      end else begin
        plen = PLEN_W'($urandom_range(0, 63));
      end
      send_request(cmd, addr, plen);
    end
  endtask

  initial begin
    int waited;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_CHECK;
    address = '0;
    prefix_len = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_edge_cases();
    test_full_table();
    test_random_traffic(350, 4, 25);
    test_random_traffic(300, 1, 40);
    test_random_traffic(150, 3, 0);

    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatch_count += expected_verdicts.size();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
